// File: rtl/bpc_pkg.sv
// Shared types and constants for the barometer pressure compensation block.
// No dependencies; every other file imports this package.
package bpc_pkg;

	localparam int AdcW   = 20;
	localparam int TfW    = 32;
	localparam int PressW = 32;
	localparam int AddrW  = 5;
	localparam int DataW  = 64;
	localparam int DivN   = 64;
	localparam int MagW   = 31;

	localparam logic signed [33:0] TfOffset = 34'sd128000;
	localparam logic [20:0] PressFull = 21'd1048576;
	localparam logic [11:0] PressScale = 12'd3125;
	localparam logic [63:0] Var1Bias = 64'h0000_8000_0000_0000;

	typedef enum logic [1:0] {
		REG_CAL_TEMP = 2'd0,
		REG_CAL_PA   = 2'd1,
		REG_CAL_PB   = 2'd2,
		REG_CAL_PC   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]        t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0]        p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} cal_t;

	typedef struct packed {
		logic signed [TfW-1:0] tf;
		logic [AdcW-1:0]       adc_p;
	} tmp_res_t;

	typedef struct packed {
		logic [63:0]           num;
		logic signed [31:0]    den;
		logic signed [TfW-1:0] tf;
		logic                  dz;
	} var_res_t;

	typedef struct packed {
		logic [63:0]           quot;
		logic                  neg;
		logic signed [TfW-1:0] tf;
		logic                  dz;
	} div_res_t;

	typedef struct packed {
		logic [PressW-1:0]     pressure;
		logic signed [TfW-1:0] tf;
		logic                  dz;
	} out_res_t;

endpackage

// File: rtl/bpc_if.sv
// Valid/ready channel interfaces for the sample and result streams.
// Depends on bpc_pkg for field widths.
interface bpc_in_if;
	import bpc_pkg::*;
	logic            valid;
	logic            ready;
	logic [AdcW-1:0] adc_pressure;
	logic [AdcW-1:0] adc_temp;
	modport source (output valid, adc_pressure, adc_temp, input ready);
	modport sink (input valid, adc_pressure, adc_temp, output ready);
endinterface

interface bpc_out_if;
	import bpc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [PressW-1:0]     pressure_q24_8;
	logic signed [TfW-1:0] temp_fine;
	logic                  divisor_zero;
	modport source (output valid, pressure_q24_8, temp_fine, divisor_zero, input ready);
	modport sink (input valid, pressure_q24_8, temp_fine, divisor_zero, output ready);
endinterface

// File: rtl/bpc_temp.sv
// Temperature compensation pipeline: three stages producing the fine temperature.
// Depends on bpc_pkg.
module bpc_temp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [bpc_pkg::AdcW-1:0] adc_p,
	input  logic [bpc_pkg::AdcW-1:0] adc_t,
	input  bpc_pkg::cal_t       cal,
	output logic                out_valid,
	output bpc_pkg::tmp_res_t   out
);
	import bpc_pkg::*;

	logic signed [18:0] a_c;
	logic signed [17:0] d_c;
	logic signed [34:0] pa_c;
	logic signed [35:0] dd_c;
	logic signed [31:0] sq_c;
	logic signed [47:0] p3_c;

	logic              v_s1, v_s2, v_s3;
	logic [31:0]       pa_s1, dd_s1;
	logic [AdcW-1:0]   ap_s1, ap_s2, ap_s3;
	logic signed [31:0] tv1_s2, p3_s2, tf_s3;

	assign a_c  = $signed({2'b00, adc_t[19:3]}) - $signed({2'b00, cal.t1, 1'b0});
	assign d_c  = $signed({2'b00, adc_t[19:4]}) - $signed({2'b00, cal.t1});
	assign pa_c = a_c * $signed(cal.t2);
	assign dd_c = d_c * d_c;
	assign sq_c = $signed(dd_s1) >>> 12;
	assign p3_c = sq_c * $signed(cal.t3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1  <= pa_c[31:0];
			dd_s1  <= dd_c[31:0];
			ap_s1  <= adc_p;
			tv1_s2 <= $signed(pa_s1) >>> 11;
			p3_s2  <= p3_c[31:0];
			ap_s2  <= ap_s1;
			tf_s3  <= tv1_s2 + ($signed(p3_s2) >>> 14);
			ap_s3  <= ap_s2;
		end
	end

	assign out_valid = v_s3;
	assign out.tf    = tf_s3;
	assign out.adc_p = ap_s3;
endmodule

// File: rtl/bpc_var.sv
// Pressure pre-compensation pipeline: forms the 64-bit dividend and 32-bit divisor terms.
// Wide products are split into 32-bit partial products. Depends on bpc_pkg.
module bpc_var (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  bpc_pkg::tmp_res_t in,
	input  bpc_pkg::cal_t     cal,
	output logic              out_valid,
	output bpc_pkg::var_res_t out
);
	import bpc_pkg::*;

	logic [8:1] v;
	logic signed [31:0] tf_s [1:8];

	logic signed [33:0] v1_s1;
	logic [AdcW-1:0]    ap_s1, ap_s2, ap_s3, ap_s4, ap_s5;

	logic signed [67:0] vv_c;
	logic signed [49:0] m5_c, m2_c;
	logic [63:0]        vv_s2;
	logic signed [49:0] m5_s2, m2_s2, m5_s3, m2_s3;

	logic signed [48:0] a6l_c, a6h_c, a3l_c, a3h_c;
	logic signed [48:0] a6l_s3, a3l_s3;
	logic [31:0]        a6h_s3, a3h_s3;

	logic [63:0] x6_s4, x3_s4;
	logic signed [49:0] m5_s4, m2_s4;

	logic [63:0] v2_s5, v1s_s5;

	logic [20:0] p0_c;
	logic [63:0] y_s6, n_s6;

	logic [47:0] yl_c;
	logic [31:0] yh_c, nh_c;
	logic [43:0] nl_c;
	logic [47:0] yl_s7;
	logic [31:0] yh_s7, nh_s7;
	logic [43:0] nl_s7;

	logic [63:0] yp_c;
	logic [63:0] num_s8;
	logic signed [31:0] den_s8;

	assign vv_c = v1_s1 * v1_s1;
	assign m5_c = v1_s1 * $signed(cal.p5);
	assign m2_c = v1_s1 * $signed(cal.p2);

	assign a6l_c = $signed({1'b0, vv_s2[31:0]}) * $signed(cal.p6);
	assign a6h_c = $signed({1'b0, vv_s2[63:32]}) * $signed(cal.p6);
	assign a3l_c = $signed({1'b0, vv_s2[31:0]}) * $signed(cal.p3);
	assign a3h_c = $signed({1'b0, vv_s2[63:32]}) * $signed(cal.p3);

	assign p0_c = PressFull - {1'b0, ap_s5};

	assign yl_c = y_s6[31:0] * cal.p1;
	assign yh_c = y_s6[63:32] * {16'b0, cal.p1};
	assign nl_c = n_s6[31:0] * PressScale;
	assign nh_c = n_s6[63:32] * {20'b0, PressScale};

	assign yp_c = {16'b0, yl_s7} + {yh_s7, 32'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else if (en) begin
			v <= {v[7:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tf_s[1] <= in.tf;
			for (int k = 2; k <= 8; k++) tf_s[k] <= tf_s[k-1];

			v1_s1 <= $signed({{2{in.tf[31]}}, in.tf}) - TfOffset;
			ap_s1 <= in.adc_p;

			vv_s2 <= vv_c[63:0];
			m5_s2 <= m5_c;
			m2_s2 <= m2_c;
			ap_s2 <= ap_s1;

			a6l_s3 <= a6l_c;
			a6h_s3 <= a6h_c[31:0];
			a3l_s3 <= a3l_c;
			a3h_s3 <= a3h_c[31:0];
			m5_s3  <= m5_s2;
			m2_s3  <= m2_s2;
			ap_s3  <= ap_s2;

			x6_s4 <= {{15{a6l_s3[48]}}, a6l_s3} + {a6h_s3, 32'b0};
			x3_s4 <= {{15{a3l_s3[48]}}, a3l_s3} + {a3h_s3, 32'b0};
			m5_s4 <= m5_s3;
			m2_s4 <= m2_s3;
			ap_s4 <= ap_s3;

			v2_s5  <= x6_s4 + ({{14{m5_s4[49]}}, m5_s4} << 17)
				+ ({{48{cal.p4[15]}}, cal.p4} << 35);
			v1s_s5 <= 64'($signed(x3_s4) >>> 8) + ({{14{m2_s4[49]}}, m2_s4} << 12);
			ap_s5  <= ap_s4;

			y_s6 <= v1s_s5 + Var1Bias;
			n_s6 <= {12'b0, p0_c, 31'b0} - v2_s5;

			yl_s7 <= yl_c;
			yh_s7 <= yh_c;
			nl_s7 <= nl_c;
			nh_s7 <= nh_c;

			den_s8 <= $signed({yp_c[63], yp_c[63:33]});
			num_s8 <= {20'b0, nl_s7} + {nh_s7, 32'b0};
		end
	end

	assign out_valid = v[8];
	assign out.num   = num_s8;
	assign out.den   = den_s8;
	assign out.tf    = tf_s[8];
	assign out.dz    = (den_s8 == 32'sd0);
endmodule

// File: rtl/bpc_div.sv
// Pipelined signed divider: one restoring step per stage, truncating toward zero.
// Depends on bpc_pkg.
module bpc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  bpc_pkg::var_res_t in,
	output logic              out_valid,
	output bpc_pkg::div_res_t out
);
	import bpc_pkg::*;

	logic [DivN:0]      v;
	logic [63:0]        q_s   [0:DivN];
	logic [MagW-1:0]    r_s   [0:DivN];
	logic [MagW-1:0]    md_s  [0:DivN];
	logic               neg_s [0:DivN];
	logic               dz_s  [0:DivN];
	logic signed [31:0] tf_s  [0:DivN];

	logic [31:0] dmag_c;

	assign dmag_c = in.den[31] ? 32'(32'd0 - in.den) : in.den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else if (en) begin
			v <= {v[DivN-1:0], in_valid};
		end
	end

	// Entry stage takes magnitudes; a zero divisor is replaced since its result is masked.
	always_ff @(posedge clk) begin
		if (en) begin
			q_s[0]   <= in.num[63] ? 64'(64'd0 - in.num) : in.num;
			r_s[0]   <= '0;
			md_s[0]  <= in.dz ? MagW'(1) : dmag_c[MagW-1:0];
			neg_s[0] <= in.num[63] ^ in.den[31];
			dz_s[0]  <= in.dz;
			tf_s[0]  <= in.tf;
		end
	end

	for (genvar k = 0; k < DivN; k++) begin : g_step
		logic [MagW:0] sh_c;
		logic          ge_c;
		logic [MagW:0] diff_c;

		assign sh_c   = {r_s[k], q_s[k][63]};
		assign ge_c   = sh_c >= {1'b0, md_s[k]};
		assign diff_c = sh_c - {1'b0, md_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k+1]   <= ge_c ? diff_c[MagW-1:0] : sh_c[MagW-1:0];
				q_s[k+1]   <= {q_s[k][62:0], ge_c};
				md_s[k+1]  <= md_s[k];
				neg_s[k+1] <= neg_s[k];
				dz_s[k+1]  <= dz_s[k];
				tf_s[k+1]  <= tf_s[k];
			end
		end
	end

	assign out_valid = v[DivN];
	assign out.quot  = q_s[DivN];
	assign out.neg   = neg_s[DivN];
	assign out.tf    = tf_s[DivN];
	assign out.dz    = dz_s[DivN];
endmodule

// File: rtl/bpc_post.sv
// Final pressure correction pipeline: quadratic P9 and linear P8 terms, P7 offset,
// saturation to unsigned Q24.8. Depends on bpc_pkg.
module bpc_post (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  bpc_pkg::div_res_t in,
	input  bpc_pkg::cal_t     cal,
	output logic              out_valid,
	output bpc_pkg::out_res_t out
);
	import bpc_pkg::*;

	logic [7:1] v;
	logic signed [31:0] tf_s [1:7];
	logic               dz_s [1:7];

	logic [63:0] p_s1, p_s2, p_s3, p_s4, p_s5;
	logic [63:0] ph_c;
	logic [63:0] sqa_c;
	logic [31:0] sqb_c;
	logic signed [48:0] w2l_c, w2h_c, w1l_c, w1h_c;

	logic [63:0]        sqa_s2;
	logic [31:0]        sqb_s2;
	logic signed [48:0] w2l_s2;
	logic [31:0]        w2h_s2;

	logic [63:0] sq2_s3, w2_s3;

	logic signed [48:0] w1l_s4;
	logic [31:0]        w1h_s4;
	logic [63:0]        w2a_s4, w2a_s5;

	logic [63:0] w1_s5;
	logic [63:0] s_s6;
	logic [63:0] r_c;
	logic [PressW-1:0] press_s7;

	assign ph_c  = 64'($signed(p_s1) >>> 13);
	assign sqa_c = ph_c[31:0] * ph_c[31:0];
	assign sqb_c = ph_c[31:0] * ph_c[63:32];
	assign w2l_c = $signed({1'b0, p_s1[31:0]}) * $signed(cal.p8);
	assign w2h_c = $signed({1'b0, p_s1[63:32]}) * $signed(cal.p8);
	assign w1l_c = $signed({1'b0, sq2_s3[31:0]}) * $signed(cal.p9);
	assign w1h_c = $signed({1'b0, sq2_s3[63:32]}) * $signed(cal.p9);

	assign r_c = 64'($signed(s_s6) >>> 8) + {{44{cal.p7[15]}}, cal.p7, 4'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else if (en) begin
			v <= {v[6:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tf_s[1] <= in.tf;
			dz_s[1] <= in.dz;
			for (int k = 2; k <= 7; k++) begin
				tf_s[k] <= tf_s[k-1];
				dz_s[k] <= dz_s[k-1];
			end

			p_s1 <= in.neg ? 64'(64'd0 - in.quot) : in.quot;

			sqa_s2 <= sqa_c;
			sqb_s2 <= sqb_c;
			w2l_s2 <= w2l_c;
			w2h_s2 <= w2h_c[31:0];
			p_s2   <= p_s1;

			// The cross term of the square appears twice, hence the extra shift.
			sq2_s3 <= sqa_s2 + {sqb_s2[30:0], 1'b0, 32'b0};
			w2_s3  <= {{15{w2l_s2[48]}}, w2l_s2} + {w2h_s2, 32'b0};
			p_s3   <= p_s2;

			w1l_s4 <= w1l_c;
			w1h_s4 <= w1h_c[31:0];
			w2a_s4 <= 64'($signed(w2_s3) >>> 19);
			p_s4   <= p_s3;

			w1_s5  <= {{15{w1l_s4[48]}}, w1l_s4} + {w1h_s4, 32'b0};
			w2a_s5 <= w2a_s4;
			p_s5   <= p_s4;

			s_s6 <= p_s5 + 64'($signed(w1_s5) >>> 25) + w2a_s5;

			if (dz_s[6] || r_c[63]) begin
				press_s7 <= '0;
			end else if (r_c[63:32] != 32'd0) begin
				press_s7 <= '1;
			end else begin
				press_s7 <= r_c[31:0];
			end
		end
	end

	assign out_valid    = v[7];
	assign out.pressure = press_s7;
	assign out.tf       = tf_s[7];
	assign out.dz       = dz_s[7];
endmodule

// File: rtl/barometer_pressure_compensation_top.sv
// Top level of the barometer pressure compensation block: calibration registers,
// pipeline units and the output register. Depends on bpc_pkg, bpc_if and the bpc_* units.
//
// Usage:
//   sample (sink)  : one item carries a raw 20-bit pressure and temperature conversion.
//   result (source): one item per sample with pressure in Pa (unsigned Q24.8), the fine
//                    temperature and a flag for a zero divisor term (pressure then 0).
//   APB port       : four calibration registers at byte addresses 0, 8, 16 and 24,
//                    64-bit data, pready always high. Write them only while idle.
// Throughput is one item per cycle while the receiver does not stall. From acceptance to the
// result an item passes 3 temperature stages, 8 stages for the dividend and divisor terms,
// 65 stages of the divider (an entry stage, then one quotient bit per stage), 7 correction
// stages and the output register. The divider's 64 quotient bits set the depth.
// When the receiver stalls, the whole pipeline holds and sample.ready drops; no
// item is lost or repeated. While the output register is empty, sample.ready is
// high even if result.ready is low.
// Reset clears all valid bits and the calibration registers to zero.
module barometer_pressure_compensation_top (
	input  logic                        clk,
	input  logic                        arst_n,
	bpc_in_if.sink                      sample,
	bpc_out_if.source                   result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bpc_pkg::AddrW-1:0]   paddr,
	input  logic [bpc_pkg::DataW-1:0]   pwdata,
	output logic [bpc_pkg::DataW-1:0]   prdata,
	output logic                        pready
);
	import bpc_pkg::*;

	logic [47:0] cal_temp_q;
	logic [63:0] cal_pa_q, cal_pb_q;
	logic [15:0] cal_pc_q;
	cal_t        cal;
	reg_idx_t    ridx;
	logic        wr;

	logic      adv;
	logic      tmp_v, var_v, div_v, post_v;
	tmp_res_t  tmp_r;
	var_res_t  var_r;
	div_res_t  div_r;
	out_res_t  post_r, res_q;
	logic      res_valid_q;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[4:3]);
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q <= '0;
			cal_pa_q   <= '0;
			cal_pb_q   <= '0;
			cal_pc_q   <= '0;
		end else if (wr) begin
			unique case (ridx)
				REG_CAL_TEMP: cal_temp_q <= pwdata[47:0];
				REG_CAL_PA:   cal_pa_q   <= pwdata;
				REG_CAL_PB:   cal_pb_q   <= pwdata;
				REG_CAL_PC:   cal_pc_q   <= pwdata[15:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_CAL_TEMP: prdata = {16'b0, cal_temp_q};
			REG_CAL_PA:   prdata = cal_pa_q;
			REG_CAL_PB:   prdata = cal_pb_q;
			REG_CAL_PC:   prdata = {48'b0, cal_pc_q};
			default:      prdata = '0;
		endcase
	end

	assign cal.t1 = cal_temp_q[15:0];
	assign cal.t2 = cal_temp_q[31:16];
	assign cal.t3 = cal_temp_q[47:32];
	assign cal.p1 = cal_pa_q[15:0];
	assign cal.p2 = cal_pa_q[31:16];
	assign cal.p3 = cal_pa_q[47:32];
	assign cal.p4 = cal_pa_q[63:48];
	assign cal.p5 = cal_pb_q[15:0];
	assign cal.p6 = cal_pb_q[31:16];
	assign cal.p7 = cal_pb_q[47:32];
	assign cal.p8 = cal_pb_q[63:48];
	assign cal.p9 = cal_pc_q;

	// The pipeline moves whenever the output register is free or being emptied.
	assign adv          = ~res_valid_q | result.ready;
	assign sample.ready = adv;

	bpc_temp u_temp (
		.clk, .arst_n, .en(adv), .in_valid(sample.valid),
		.adc_p(sample.adc_pressure), .adc_t(sample.adc_temp), .cal,
		.out_valid(tmp_v), .out(tmp_r)
	);

	bpc_var u_var (
		.clk, .arst_n, .en(adv), .in_valid(tmp_v), .in(tmp_r), .cal,
		.out_valid(var_v), .out(var_r)
	);

	bpc_div u_div (
		.clk, .arst_n, .en(adv), .in_valid(var_v), .in(var_r),
		.out_valid(div_v), .out(div_r)
	);

	bpc_post u_post (
		.clk, .arst_n, .en(adv), .in_valid(div_v), .in(div_r), .cal,
		.out_valid(post_v), .out(post_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= post_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= post_r;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.pressure_q24_8 = res_q.pressure;
	assign result.temp_fine      = res_q.tf;
	assign result.divisor_zero   = res_q.dz;
endmodule

// File: rtl/bpc_checker.sv
// Port-level checks for the barometer pressure compensation top level, with its bind.
// Depends on bpc_pkg and barometer_pressure_compensation_top.
module bpc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_ready,
	input logic                          r_valid,
	input logic                          r_ready,
	input logic [bpc_pkg::PressW-1:0]    r_pressure,
	input logic                          r_dz
);
	import bpc_pkg::*;

	// A stalled result holds the pipeline, so no new item may enter.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |-> !s_ready)
		else $error("sample accepted while result stalled");

	// An empty output register always leaves room for a new item.
	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!r_valid |-> s_ready)
		else $error("sample refused while output register empty");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_dz |-> r_pressure == '0)
		else $error("pressure not zero with divisor_zero set");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_pressure))
		else $error("stalled result item changed");
endmodule

bind barometer_pressure_compensation_top bpc_checker u_bpc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_ready(sample.ready),
	.r_valid(result.valid),
	.r_ready(result.ready),
	.r_pressure(result.pressure_q24_8),
	.r_dz(result.divisor_zero)
);
